[sv/hbp_pkg.sv]
// Package with the constants, types and helper functions of the hybrid branch predictor.
`timescale 1ns / 1ps
`default_nettype none
package hbp_pkg;

    localparam int BIMODAL_BITS_MAX = 12;
    localparam int GSHARE_BITS_MAX  = 12;
    localparam int CHOOSER_BITS_MAX = 12;
    localparam int ADDRESS_WIDTH    = 32;

    localparam int WORD_W = ADDRESS_WIDTH - 2;
    localparam int IDX_MAX_01 =
        (BIMODAL_BITS_MAX > GSHARE_BITS_MAX) ? BIMODAL_BITS_MAX : GSHARE_BITS_MAX;
    localparam int IDX_MAX = (IDX_MAX_01 > CHOOSER_BITS_MAX) ? IDX_MAX_01 : CHOOSER_BITS_MAX;

    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int MODE_W    = 2;
    localparam int CNT_W     = 5;
    localparam int TOTAL_W   = 32;
    localparam int CTR_W     = 2;

    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIMODAL_BITS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GSHARE_BITS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_LEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHOOSER_BITS = 3'd4;

    localparam logic [MODE_W-1:0] MODE_BIMODAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GSHARE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HYBRID  = 2'd2;

    localparam logic [MODE_W-1:0] RST_MODE         = MODE_HYBRID;
    localparam logic [CFG_W-1:0]  RST_BIMODAL_BITS = 4'd12;
    localparam logic [CFG_W-1:0]  RST_GSHARE_BITS  = 4'd12;
    localparam logic [CFG_W-1:0]  RST_HISTORY_LEN  = 4'd8;
    localparam logic [CFG_W-1:0]  RST_CHOOSER_BITS = 4'd10;

    localparam logic [CTR_W-1:0] CTR_INIT_PRED   = 2'd2;
    localparam logic [CTR_W-1:0] CTR_INIT_CHOOSE = 2'd1;
    localparam logic [CTR_W-1:0] CTR_TOP         = 2'd3;

    typedef logic [CTR_W-1:0] t_ctr;

    typedef struct packed {
        logic                 predicted_taken;
        logic                 mispredicted;
        logic                 used_gshare;
        logic [TOTAL_W-1:0]   prediction_count;
        logic [TOTAL_W-1:0]   misprediction_count;
    } t_result;

    function automatic t_ctr train(input t_ctr ctr, input logic up);
        t_ctr res;
        res = ctr;
        if (up) begin
            if (ctr != CTR_TOP) res = ctr + 2'd1;
        end else begin
            if (ctr != '0) res = ctr - 2'd1;
        end
        return res;
    endfunction

    function automatic logic [CNT_W-1:0] clamp(input logic [CFG_W-1:0] v, input int max);
        logic [CNT_W-1:0] res;
        res = CNT_W'(v);
        if (res > CNT_W'(max)) res = CNT_W'(max);
        return res;
    endfunction

endpackage
`default_nettype wire

[sv/hbp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered, write-first read.
`timescale 1ns / 1ps
`default_nettype none
module hbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            o_rdata <= i_wdata;
        end else begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

[sv/hybrid_branch_predictor_unit.sv]
// Top level of the hybrid bimodal, gshare and tournament branch predictor.
// After reset the block sweeps every entry of its largest counter table (4096 entries),
// writing the reset values into all three tables, and holds o_stall high meanwhile;
// configuration writes are taken at any time. After that it takes one resolved branch
// per cycle while o_stall is low, and writes each result into the output queue from
// stage one: the tables are read in the cycle an item is accepted, and the prediction and
// training happen in the next cycle from the registered read data, with the counter
// memories written back while the following item reads them. Results pass through a
// three-entry output queue, so a stalled consumer does not stop the input until the
// queue is full.
`timescale 1ns / 1ps
`default_nettype none
module hybrid_branch_predictor_unit (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [hbp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [hbp_pkg::CFG_W-1:0]             i_cfg_data,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic [hbp_pkg::ADDRESS_WIDTH-1:0]     i_branch_address,
    input  wire logic                                  i_taken,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic                                       o_predicted_taken,
    output logic                                       o_mispredicted,
    output logic                                       o_used_gshare,
    output logic [hbp_pkg::TOTAL_W-1:0]                o_prediction_count,
    output logic [hbp_pkg::TOTAL_W-1:0]                o_misprediction_count
);

    localparam int BB = hbp_pkg::BIMODAL_BITS_MAX;
    localparam int GB = hbp_pkg::GSHARE_BITS_MAX;
    localparam int CB = hbp_pkg::CHOOSER_BITS_MAX;
    localparam int XB = hbp_pkg::IDX_MAX;

    // Configuration registers.
    logic [hbp_pkg::MODE_W-1:0] r_mode;
    logic [hbp_pkg::CFG_W-1:0]  r_bb_cfg;
    logic [hbp_pkg::CFG_W-1:0]  r_gb_cfg;
    logic [hbp_pkg::CFG_W-1:0]  r_hl_cfg;
    logic [hbp_pkg::CFG_W-1:0]  r_cb_cfg;

    // Control state.
    logic                            r_clr_busy;
    logic [XB-1:0]                   r_clr_addr;
    logic                            r_s1_valid;
    logic [GB-1:0]                   r_hist;
    logic [GB-1:0]                   n_hist;
    logic [hbp_pkg::TOTAL_W-1:0]     r_pred_total;
    logic [hbp_pkg::TOTAL_W-1:0]     r_mispred_total;
    logic [hbp_pkg::TOTAL_W-1:0]     n_pred_total;
    logic [hbp_pkg::TOTAL_W-1:0]     n_mispred_total;
    logic [hbp_pkg::FIFO_CNT_W-1:0]  r_count;
    logic [hbp_pkg::FIFO_PTR_W-1:0]  r_wr_ptr;
    logic [hbp_pkg::FIFO_PTR_W-1:0]  r_rd_ptr;

    // Stage one payload.
    logic [BB-1:0] r_s1_bi;
    logic [GB-1:0] r_s1_gi;
    logic [CB-1:0] r_s1_ci;
    logic          r_s1_taken;

    hbp_pkg::t_result r_fifo [hbp_pkg::FIFO_DEPTH];
    hbp_pkg::t_result w_result;

    logic w_in_acc;
    logic w_out_acc;
    logic w_cfg_acc;

    logic [hbp_pkg::CNT_W-1:0] w_bb;
    logic [hbp_pkg::CNT_W-1:0] w_gb;
    logic [hbp_pkg::CNT_W-1:0] w_cb;
    logic [hbp_pkg::CNT_W-1:0] w_hn;

    logic [XB+hbp_pkg::WORD_W-1:0] w_word;
    logic [GB-1:0] w_hist_mask;
    logic [GB-1:0] w_hist;
    logic [BB-1:0] w_bi;
    logic [GB-1:0] w_gi;
    logic [CB-1:0] w_ci;

    hbp_pkg::t_ctr w_b_rd;
    hbp_pkg::t_ctr w_g_rd;
    hbp_pkg::t_ctr w_c_rd;

    logic w_use_g;
    logic w_pred;
    logic w_miss;
    logic w_b_upd;
    logic w_g_upd;
    logic w_c_upd;

    logic          w_b_we;
    logic          w_g_we;
    logic          w_c_we;
    logic [BB-1:0] w_b_waddr;
    logic [GB-1:0] w_g_waddr;
    logic [CB-1:0] w_c_waddr;
    hbp_pkg::t_ctr w_b_wdata;
    hbp_pkg::t_ctr w_g_wdata;
    hbp_pkg::t_ctr w_c_wdata;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign o_stall     = r_clr_busy ||
        ((r_count + hbp_pkg::FIFO_CNT_W'(r_s1_valid)) >=
         hbp_pkg::FIFO_CNT_W'(hbp_pkg::FIFO_DEPTH));
    assign w_in_acc    = i_valid && !o_stall;
    assign o_valid     = (r_count != '0);
    assign w_out_acc   = o_valid && !i_stall;

    // Index formation for the item at the input.
    always_comb begin
        w_bb        = hbp_pkg::clamp(r_bb_cfg, BB);
        w_gb        = hbp_pkg::clamp(r_gb_cfg, GB);
        w_cb        = hbp_pkg::clamp(r_cb_cfg, CB);
        w_hn        = (hbp_pkg::CNT_W'(r_hl_cfg) > w_gb) ? w_gb : hbp_pkg::CNT_W'(r_hl_cfg);
        w_word      = {{XB{1'b0}}, i_branch_address[hbp_pkg::ADDRESS_WIDTH-1:2]};
        w_hist_mask = ~({GB{1'b1}} << w_hn);
        w_hist      = r_hist & w_hist_mask;
        w_bi        = w_word[BB-1:0] & ~({BB{1'b1}} << w_bb);
        w_gi        = (w_word[GB-1:0] & ~({GB{1'b1}} << w_gb)) ^ (w_hist << (w_gb - w_hn));
        w_ci        = w_word[CB-1:0] & ~({CB{1'b1}} << w_cb);
        n_hist      = r_hist;
        if ((r_mode != hbp_pkg::MODE_BIMODAL) && (w_hn != '0)) begin
            n_hist = ((w_hist >> 1) | (GB'(i_taken) << (w_hn - hbp_pkg::CNT_W'(1))))
                     & w_hist_mask;
        end
    end

    // Prediction and training for the item in stage one.
    always_comb begin
        unique case (r_mode)
            hbp_pkg::MODE_BIMODAL: w_use_g = 1'b0;
            hbp_pkg::MODE_GSHARE:  w_use_g = 1'b1;
            default:               w_use_g = w_c_rd[1];
        endcase
        w_pred  = w_use_g ? w_g_rd[1] : w_b_rd[1];
        w_miss  = (w_pred != r_s1_taken);
        w_g_upd = r_s1_valid && w_use_g;
        w_b_upd = r_s1_valid && !w_use_g;
        w_c_upd = r_s1_valid && (r_mode >= hbp_pkg::MODE_HYBRID) && (w_g_rd[1] != w_b_rd[1]);

        n_pred_total    = (r_pred_total == '1) ? r_pred_total
                                               : r_pred_total + hbp_pkg::TOTAL_W'(1);
        n_mispred_total = r_mispred_total;
        if (w_miss && (r_mispred_total != '1)) begin
            n_mispred_total = r_mispred_total + hbp_pkg::TOTAL_W'(1);
        end

        w_result.predicted_taken     = w_pred;
        w_result.mispredicted        = w_miss;
        w_result.used_gshare         = w_use_g;
        w_result.prediction_count    = n_pred_total;
        w_result.misprediction_count = n_mispred_total;
    end

    // Memory write ports: the clearing sweep after reset, then training.
    always_comb begin
        if (r_clr_busy) begin
            w_b_we    = ((r_clr_addr >> BB) == '0);
            w_g_we    = ((r_clr_addr >> GB) == '0);
            w_c_we    = ((r_clr_addr >> CB) == '0);
            w_b_waddr = r_clr_addr[BB-1:0];
            w_g_waddr = r_clr_addr[GB-1:0];
            w_c_waddr = r_clr_addr[CB-1:0];
            w_b_wdata = hbp_pkg::CTR_INIT_PRED;
            w_g_wdata = hbp_pkg::CTR_INIT_PRED;
            w_c_wdata = hbp_pkg::CTR_INIT_CHOOSE;
        end else begin
            w_b_we    = w_b_upd;
            w_g_we    = w_g_upd;
            w_c_we    = w_c_upd;
            w_b_waddr = r_s1_bi;
            w_g_waddr = r_s1_gi;
            w_c_waddr = r_s1_ci;
            w_b_wdata = hbp_pkg::train(w_b_rd, r_s1_taken);
            w_g_wdata = hbp_pkg::train(w_g_rd, r_s1_taken);
            w_c_wdata = hbp_pkg::train(w_c_rd, w_g_rd[1] == r_s1_taken);
        end
    end

    hbp_ram #(.WIDTH(hbp_pkg::CTR_W), .DEPTH(1 << BB)) u_bimodal_ram (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (w_b_waddr),
        .i_wdata (w_b_wdata),
        .i_raddr (w_bi),
        .o_rdata (w_b_rd)
    );

    hbp_ram #(.WIDTH(hbp_pkg::CTR_W), .DEPTH(1 << GB)) u_gshare_ram (
        .i_clk   (i_clk),
        .i_we    (w_g_we),
        .i_waddr (w_g_waddr),
        .i_wdata (w_g_wdata),
        .i_raddr (w_gi),
        .o_rdata (w_g_rd)
    );

    hbp_ram #(.WIDTH(hbp_pkg::CTR_W), .DEPTH(1 << CB)) u_chooser_ram (
        .i_clk   (i_clk),
        .i_we    (w_c_we),
        .i_waddr (w_c_waddr),
        .i_wdata (w_c_wdata),
        .i_raddr (w_ci),
        .o_rdata (w_c_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= hbp_pkg::RST_MODE;
            r_bb_cfg        <= hbp_pkg::RST_BIMODAL_BITS;
            r_gb_cfg        <= hbp_pkg::RST_GSHARE_BITS;
            r_hl_cfg        <= hbp_pkg::RST_HISTORY_LEN;
            r_cb_cfg        <= hbp_pkg::RST_CHOOSER_BITS;
            r_clr_busy      <= 1'b1;
            r_clr_addr      <= '0;
            r_s1_valid      <= 1'b0;
            r_hist          <= '0;
            r_pred_total    <= '0;
            r_mispred_total <= '0;
            r_count         <= '0;
            r_wr_ptr        <= '0;
            r_rd_ptr        <= '0;
        end else begin
            if (w_cfg_acc) begin
                unique case (i_cfg_index)
                    hbp_pkg::CFG_MODE:         r_mode   <= i_cfg_data[hbp_pkg::MODE_W-1:0];
                    hbp_pkg::CFG_BIMODAL_BITS: r_bb_cfg <= i_cfg_data;
                    hbp_pkg::CFG_GSHARE_BITS:  r_gb_cfg <= i_cfg_data;
                    hbp_pkg::CFG_HISTORY_LEN:  r_hl_cfg <= i_cfg_data;
                    hbp_pkg::CFG_CHOOSER_BITS: r_cb_cfg <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + XB'(1);
                if (r_clr_addr == '1) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_s1_valid <= w_in_acc;
            if (w_in_acc) begin
                r_hist <= n_hist;
            end
            if (r_s1_valid) begin
                r_pred_total    <= n_pred_total;
                r_mispred_total <= n_mispred_total;
                r_wr_ptr <= (r_wr_ptr == hbp_pkg::FIFO_PTR_W'(hbp_pkg::FIFO_DEPTH - 1))
                            ? '0 : r_wr_ptr + hbp_pkg::FIFO_PTR_W'(1);
            end
            if (w_out_acc) begin
                r_rd_ptr <= (r_rd_ptr == hbp_pkg::FIFO_PTR_W'(hbp_pkg::FIFO_DEPTH - 1))
                            ? '0 : r_rd_ptr + hbp_pkg::FIFO_PTR_W'(1);
            end
            r_count <= r_count + hbp_pkg::FIFO_CNT_W'(r_s1_valid)
                       - hbp_pkg::FIFO_CNT_W'(w_out_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_bi    <= w_bi;
            r_s1_gi    <= w_gi;
            r_s1_ci    <= w_ci;
            r_s1_taken <= i_taken;
        end
        if (r_s1_valid) begin
            r_fifo[r_wr_ptr] <= w_result;
        end
    end

    assign o_predicted_taken     = r_fifo[r_rd_ptr].predicted_taken;
    assign o_mispredicted        = r_fifo[r_rd_ptr].mispredicted;
    assign o_used_gshare         = r_fifo[r_rd_ptr].used_gshare;
    assign o_prediction_count    = r_fifo[r_rd_ptr].prediction_count;
    assign o_misprediction_count = r_fifo[r_rd_ptr].misprediction_count;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count + hbp_pkg::FIFO_CNT_W'(r_s1_valid)) <=
        hbp_pkg::FIFO_CNT_W'(hbp_pkg::FIFO_DEPTH))
        else $error("Output queue and stage one hold more items than the queue depth.");

    a_no_item_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_s1_valid && !w_in_acc)
        else $error("An item entered the pipeline during the table clearing sweep.");

    a_totals_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mispred_total <= r_pred_total)
        else $error("Misprediction total exceeds prediction total.");

    a_one_component: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_clr_busy |-> $onehot0({w_b_we, w_g_we}))
        else $error("Both predictor components were trained by one item.");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |=> o_valid)
        else $error("A finished item did not reach the output queue.");

endmodule
`default_nettype wire
